@@ rtl/rdb_pkg.sv @@
`default_nettype none

package rdb_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_BACK   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;
    localparam logic [2:0] CMD_INSERT     = 3'd5;
    localparam logic [2:0] CMD_ERASE      = 3'd6;
    localparam logic [2:0] CMD_CLEAR      = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [3:0]  position;
        logic [3:0]  position_end;
    } rdb_in_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [4:0]  count;
        logic        is_empty;
        logic        is_full;
        logic [1:0]  status;
    } rdb_out_t;

endpackage

`default_nettype wire

@@ rtl/rdb_ram.sv @@
`default_nettype none

module rdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/ring_deque_buffer.sv @@
`default_nettype none

// Double-ended ring buffer. A command is taken when start is high and busy is low; its single
// result appears on result for exactly one cycle with done high and cannot be held off, so the
// receiver must take every beat as it comes. Push, pop, read and clear go from accept to done
// through the execute, slot-read, front-read, back-read and finish states. Insert and erase
// move live entries one per cycle through the store's read and write ports in a move state
// between execute and slot-read, at most capacity - 1 entries; an insert or erase that is
// refused or that erases an empty range skips the move state. The store reads as zero in every
// slot after reset until the slot is written. Writing cfg_wdata sets the capacity in use and
// empties the ring; the store keeps its words.
module ring_deque_buffer
    import rdb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire rdb_in_t          item,
    output logic                  busy,
    output logic                  done,
    output rdb_out_t              result,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_MOVE     = 3'd2;
    localparam logic [2:0] S_RD_SLOT  = 3'd3;
    localparam logic [2:0] S_RD_FRONT = 3'd4;
    localparam logic [2:0] S_RD_BACK  = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0]            state_reg, state_next;
    rdb_in_t               item_reg, item_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [1:0]            status_reg, status_next;
    logic [CNT_W-1:0]      moves_reg, moves_next;
    logic [CNT_W-1:0]      span_reg, span_next;
    logic [PTR_W-1:0]      src_reg, src_next;
    logic [PTR_W-1:0]      dst_reg, dst_next;
    logic                  inflight_reg, inflight_next;
    logic                  rd_valid_reg;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    rdb_out_t              result_reg, result_next;
    logic                  done_reg, done_next;

    logic [CNT_W-1:0]      cap;
    logic [PTR_W-1:0]      cap_m1;
    logic                  full;
    logic                  empty;
    logic [CNT_W-1:0]      dist_k;
    logic [CNT_W-1:0]      dist_n;
    logic [CNT_W:0]        dist_kn;
    logic                  pos_ok;
    logic                  pend_ok;
    logic                  shift_down;

    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] rd_word;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
        return (p == last) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
        return (p == '0) ? last : PTR_W'(p - 1'b1);
    endfunction

    // Distance from b up to a around a ring of c slots, both below c.
    function automatic logic [CNT_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                   input logic [PTR_W-1:0] b,
                                                   input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] a_w;
        logic [CNT_W-1:0] b_w;
        a_w = CNT_W'(a);
        b_w = CNT_W'(b);
        return (a_w >= b_w) ? CNT_W'(a_w - b_w) : CNT_W'(a_w + c - b_w);
    endfunction

    rdb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (CNT_W'(cap_reg) > CNT_W'(DEPTH) || cap_reg > CAP_W'(DEPTH))
        begin
            cap = CNT_W'(DEPTH);
        end
        else
        begin
            cap = CNT_W'(cap_reg);
        end
    end

    assign cap_m1     = PTR_W'(cap - 1'b1);
    assign full       = (count_reg == cap);
    assign empty      = (count_reg == '0);
    assign pos_ok     = CNT_W'(item_reg.position) < cap;
    assign pend_ok    = CNT_W'(item_reg.position_end) < cap;
    assign dist_k     = ring_dist(PTR_W'(item_reg.position), head_reg, cap);
    assign dist_n     = ring_dist(PTR_W'(item_reg.position_end), PTR_W'(item_reg.position), cap);
    assign dist_kn    = {1'b0, dist_k} + {1'b0, dist_n};
    assign shift_down = (item_reg.cmd == CMD_INSERT);

    // Slots never written since reset read as zero.
    assign rd_word = rd_valid_reg ? ram_rdata : '0;

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        cap_next      = cap_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        moves_next    = moves_reg;
        span_next     = span_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        inflight_next = inflight_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = tail_reg;
        ram_wdata     = item_reg.value;
        ram_raddr     = src_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    status_next = ST_OK;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RD_SLOT;
                unique case (item_reg.cmd)
                    CMD_PUSH_BACK:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = tail_reg;
                        tail_next = ptr_inc(tail_reg, cap_m1);
                        if (full)
                        begin
                            head_next = ptr_inc(head_reg, cap_m1);
                        end
                        else
                        begin
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    CMD_PUSH_FRONT:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ptr_dec(head_reg, cap_m1);
                        head_next = ptr_dec(head_reg, cap_m1);
                        if (full)
                        begin
                            tail_next = ptr_dec(tail_reg, cap_m1);
                        end
                        else
                        begin
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            count_next = CNT_W'(count_reg - 1'b1);
                            tail_next  = ptr_dec(tail_reg, cap_m1);
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            count_next = CNT_W'(count_reg - 1'b1);
                            head_next  = ptr_inc(head_reg, cap_m1);
                        end
                    end
                    CMD_READ:
                    begin
                        if (!pos_ok)
                        begin
                            status_next = ST_BAD_POS;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (!pos_ok || dist_k > count_reg)
                        begin
                            status_next = ST_BAD_POS;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // Walk from the back toward the insert slot, top entry first.
                            moves_next    = CNT_W'(count_reg - dist_k);
                            dst_next      = tail_reg;
                            src_next      = ptr_dec(tail_reg, cap_m1);
                            inflight_next = 1'b0;
                            state_next    = S_MOVE;
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (!pos_ok || !pend_ok)
                        begin
                            status_next = ST_BAD_POS;
                        end
                        else if (item_reg.position != item_reg.position_end)
                        begin
                            if (dist_kn > {1'b0, count_reg})
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                moves_next    = CNT_W'({1'b0, count_reg} - dist_kn);
                                span_next     = dist_n;
                                dst_next      = PTR_W'(item_reg.position);
                                src_next      = PTR_W'(item_reg.position_end);
                                inflight_next = 1'b0;
                                state_next    = S_MOVE;
                            end
                        end
                    end
                    CMD_CLEAR:
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_MOVE:
            begin
                // A read of the next source overlaps the write of the previous beat.
                ram_raddr     = src_reg;
                ram_waddr     = dst_reg;
                ram_wdata     = rd_word;
                inflight_next = 1'b0;
                if (inflight_reg)
                begin
                    ram_we   = 1'b1;
                    dst_next = shift_down ? ptr_dec(dst_reg, cap_m1) : ptr_inc(dst_reg, cap_m1);
                end
                if (moves_reg != '0)
                begin
                    moves_next    = CNT_W'(moves_reg - 1'b1);
                    inflight_next = 1'b1;
                    src_next = shift_down ? ptr_dec(src_reg, cap_m1) : ptr_inc(src_reg, cap_m1);
                end
                else if (!inflight_reg)
                begin
                    state_next = S_RD_SLOT;
                    if (shift_down)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = PTR_W'(item_reg.position);
                        ram_wdata  = item_reg.value;
                        tail_next  = ptr_inc(tail_reg, cap_m1);
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        tail_next  = PTR_W'(ring_dist(tail_reg, PTR_W'(span_reg), cap));
                        count_next = CNT_W'(count_reg - span_reg);
                    end
                end
            end

            S_RD_SLOT:
            begin
                ram_raddr  = PTR_W'(item_reg.position);
                state_next = S_RD_FRONT;
            end

            S_RD_FRONT:
            begin
                ram_raddr = head_reg;
                if (item_reg.cmd == CMD_READ && status_reg == ST_OK)
                begin
                    result_next.read_value = rd_word;
                end
                else
                begin
                    result_next.read_value = '0;
                end
                state_next = S_RD_BACK;
            end

            S_RD_BACK:
            begin
                ram_raddr               = ptr_dec(tail_reg, cap_m1);
                result_next.front_value = empty ? '0 : rd_word;
                state_next              = S_FIN;
            end

            S_FIN:
            begin
                result_next.back_value = empty ? '0 : rd_word;
                result_next.count      = 5'(count_reg);
                result_next.is_empty   = empty;
                result_next.is_full    = full;
                result_next.status     = status_reg;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            cap_next   = cfg_wdata;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_reg      <= CAP_W'(DEPTH);
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            status_reg   <= ST_OK;
            moves_reg    <= '0;
            inflight_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            moves_reg    <= moves_next;
            inflight_reg <= inflight_next;
            rd_valid_reg <= valid_reg[ram_raddr];
            valid_reg    <= valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        span_reg   <= span_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ test/ring_deque_buffer_checker.sv @@
`default_nettype none

module ring_deque_buffer_checker
    import rdb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire rdb_in_t          item,
    input  wire logic             done,
    input  wire rdb_out_t         result,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    logic [DATA_WIDTH-1:0] words [DEPTH];
    int                    head;
    int                    tail;
    int                    live;
    logic [CAP_W-1:0]      cap_reg;
    rdb_out_t              outcome_q [$];
    int                    errors;

    function automatic int ring_size();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > DEPTH)
            return DEPTH;
        return int'(cap_reg);
    endfunction

    // Updates the shadow ring for one accepted beat and returns what the block should report.
    function automatic rdb_out_t apply_beat(rdb_in_t b);
        int       c;
        int       k;
        int       n;
        int       j;
        int       pos;
        int       pend;
        rdb_out_t r;
        c    = ring_size();
        pos  = int'(b.position);
        pend = int'(b.position_end);
        r    = '0;
        r.status = ST_OK;
        case (b.cmd)
            CMD_PUSH_BACK:
            begin
                words[tail] = b.value;
                tail = (tail + 1) % c;
                if (live == c)
                    head = (head + 1) % c;
                else
                    live++;
            end
            CMD_PUSH_FRONT:
            begin
                head = (head + c - 1) % c;
                words[head] = b.value;
                if (live == c)
                    tail = (tail + c - 1) % c;
                else
                    live++;
            end
            CMD_POP_BACK:
            begin
                if (live == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    live--;
                    tail = (tail + c - 1) % c;
                end
            end
            CMD_POP_FRONT:
            begin
                if (live == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    live--;
                    head = (head + 1) % c;
                end
            end
            CMD_READ:
            begin
                if (pos < c)
                    r.read_value = words[pos];
                else
                    r.status = ST_BAD_POS;
            end
            CMD_INSERT:
            begin
                k = (pos + c - head) % c;
                if (pos >= c || k > live)
                    r.status = ST_BAD_POS;
                else if (live == c)
                    r.status = ST_FULL;
                else
                begin
                    // Live entries from the insert point onward move up one slot, top first.
                    for (j = live; j > k; j--)
                        words[(head + j % c) % c] = words[(head + (j - 1) % c) % c];
                    words[pos] = b.value;
                    tail = (tail + 1) % c;
                    live++;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= c || pend >= c)
                    r.status = ST_BAD_POS;
                else if (pos != pend)
                begin
                    k = (pos + c - head) % c;
                    n = (pend + c - pos) % c;
                    if (k + n > live)
                        r.status = ST_BAD_POS;
                    else
                    begin
                        for (j = k + n; j < live; j++)
                            words[(head + (j - n) % c) % c] = words[(head + j % c) % c];
                        tail = (tail + c - n) % c;
                        live -= n;
                    end
                end
            end
            default:
            begin
                head = 0;
                tail = 0;
                live = 0;
            end
        endcase
        r.front_value = (live != 0) ? words[head] : '0;
        r.back_value  = (live != 0) ? words[(tail + c - 1) % c] : '0;
        r.count       = 5'(live);
        r.is_empty    = (live == 0);
        r.is_full     = (live == c);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            if (errors < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rdb_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                words[i] = '0;
            head    = 0;
            tail    = 0;
            live    = 0;
            cap_reg = CAP_W'(DEPTH);
            outcome_q.delete();
            errors  = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result beat with nothing outstanding", $time);
                    errors++;
                end
                else
                begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    check_field("read_value", want.read_value, result.read_value);
                    check_field("front_value", want.front_value, result.front_value);
                    check_field("back_value", want.back_value, result.back_value);
                    check_field("count", 32'(want.count), 32'(result.count));
                    check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(result.is_full));
                    check_field("status", 32'(want.status), 32'(result.status));
                end
            end
            if (cfg_we)
            begin
                cap_reg = cfg_wdata;
                head    = 0;
                tail    = 0;
                live    = 0;
            end
            if (start && !busy)
                outcome_q = {outcome_q, apply_beat(item)};
            pending    <= outcome_q.size();
            fail_count <= errors;
        end
    end

endmodule

`default_nettype wire

@@ test/ring_deque_buffer_tb.sv @@
`default_nettype none

module ring_deque_buffer_tb;
    import rdb_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    rdb_in_t          item;
    logic             busy;
    logic             done;
    rdb_out_t         result;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               cap_now;
    int               burst_left;

    ring_deque_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ring_deque_buffer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("ring_deque_buffer_tb: errors");
        $finish;
    end

    function automatic rdb_in_t beat(logic [2:0] cmd, logic [31:0] value, int pos, int pend);
        rdb_in_t b;
        b.cmd          = cmd;
        b.value        = value;
        b.position     = 4'(pos);
        b.position_end = 4'(pend);
        return b;
    endfunction

    function automatic int clamp_cap(logic [CAP_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return int'(v);
    endfunction

    // Positions mostly land inside the ring so that inserts and erases get past the checks.
    function automatic rdb_in_t random_beat(int c);
        rdb_in_t b;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 28)
            b.cmd = CMD_PUSH_BACK;
        else if (r < 42)
            b.cmd = CMD_PUSH_FRONT;
        else if (r < 52)
            b.cmd = CMD_POP_BACK;
        else if (r < 62)
            b.cmd = CMD_POP_FRONT;
        else if (r < 71)
            b.cmd = CMD_READ;
        else if (r < 85)
            b.cmd = CMD_INSERT;
        else if (r < 98)
            b.cmd = CMD_ERASE;
        else
            b.cmd = CMD_CLEAR;
        b.value = $urandom;
        if ($urandom_range(0, 15) == 0)
            b.value = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0)
            b.position = 4'($urandom_range(0, 15));
        else
            b.position = 4'($urandom_range(0, c - 1));
        if (b.cmd == CMD_ERASE && $urandom_range(0, 4) != 0)
            b.position_end = 4'((int'(b.position) + $urandom_range(0, 3)) % c);
        else
            b.position_end = 4'($urandom_range(0, 15));
        return b;
    endfunction

    // Leaves start high on return, so a following beat keeps it high without a glitch.
    task automatic issue(rdb_in_t b);
        start <= 1'b1;
        item  <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (24) @(posedge clk);
    endtask

    task automatic load_capacity(logic [CAP_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cap_now = clamp_cap(v);
    endtask

    task automatic random_phase(int beats);
        int gap;
        for (int n = 0; n < beats; n++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                if (gap > 0)
                    pause(gap);
                burst_left = $urandom_range(1, 24);
            end
            issue(random_beat(cap_now));
            burst_left--;
        end
    endtask

    initial
    begin
        int cap_plan [10];
        logic [CAP_W-1:0] cap_val;
        cap_plan = '{4, 1, 16, 0, 7, 31, 2, 0, 5, 16};
        start      <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        rst_n      <= 1'b0;
        cap_now    = DEPTH;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size ring from reset: empty pops, edge words, inserts and erases around the wrap.
        issue(beat(CMD_POP_BACK, 32'h0, 0, 0));
        issue(beat(CMD_POP_FRONT, 32'h0, 15, 15));
        issue(beat(CMD_READ, 32'h0, 15, 0));
        issue(beat(CMD_PUSH_BACK, 32'hFFFF_FFFF, 0, 0));
        issue(beat(CMD_PUSH_FRONT, 32'h0000_0000, 0, 0));
        issue(beat(CMD_PUSH_BACK, 32'h1234_5678, 0, 0));
        issue(beat(CMD_INSERT, 32'hA5A5_A5A5, 1, 0));
        issue(beat(CMD_INSERT, 32'h5A5A_5A5A, 5, 0));
        issue(beat(CMD_INSERT, 32'hDEAD_BEEF, 3, 0));
        issue(beat(CMD_READ, 32'h0, 0, 0));
        issue(beat(CMD_READ, 32'h0, 15, 0));
        issue(beat(CMD_ERASE, 32'h0, 0, 2));
        issue(beat(CMD_ERASE, 32'h0, 15, 15));
        issue(beat(CMD_ERASE, 32'h0, 5, 0));
        issue(beat(CMD_POP_BACK, 32'h0, 0, 0));
        issue(beat(CMD_POP_FRONT, 32'h0, 0, 0));
        issue(beat(CMD_CLEAR, 32'h0, 0, 0));
        issue(beat(CMD_INSERT, 32'hCAFE_F00D, 0, 0));

        // Small ring: overwrite at both ends, insert into a full ring, positions past the end.
        load_capacity(5'd3);
        issue(beat(CMD_PUSH_BACK, 32'h1111_1111, 0, 0));
        issue(beat(CMD_PUSH_BACK, 32'h2222_2222, 0, 0));
        issue(beat(CMD_PUSH_BACK, 32'h3333_3333, 0, 0));
        issue(beat(CMD_PUSH_BACK, 32'h4444_4444, 0, 0));
        issue(beat(CMD_PUSH_FRONT, 32'h5555_5555, 0, 0));
        issue(beat(CMD_INSERT, 32'h6666_6666, 0, 0));
        issue(beat(CMD_READ, 32'h0, 15, 0));
        issue(beat(CMD_ERASE, 32'h0, 0, 15));
        issue(beat(CMD_ERASE, 32'h0, 2, 1));

        for (int p = 0; p < 10; p++)
        begin
            cap_val = (p == 7) ? CAP_W'($urandom_range(1, 31)) : CAP_W'(cap_plan[p]);
            load_capacity(cap_val);
            random_phase(125);
        end

        drain();
        if (fail_count == 0)
            $display("ring_deque_buffer_tb: clean");
        else
            $display("ring_deque_buffer_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
